>>> rtl/dta_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dta_pkg: shared types and constants of the debounced temperature alarm
// Register indexes, field widths and the configuration bundle that is
// passed from the register bank to the channel lanes.
// ---------------------------------------------------------------------------
package dta_pkg;

	// Widths fixed by the item and register fields
	localparam int TempW   = 11;
	localparam int TimeW   = 16;
	localparam int StepW   = 10;
	localparam int CountW  = TimeW + 1;
	localparam int NumSlots = 3;

	// Stream and configuration port widths
	localparam int InDataW  = 40;
	localparam int OutDataW = 8;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	// Register indexes
	localparam logic [CfgIdxW-1:0] RegLowEnable     = 3'd0;
	localparam logic [CfgIdxW-1:0] RegLowThreshold  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegHighEnable    = 3'd2;
	localparam logic [CfgIdxW-1:0] RegHighThreshold = 3'd3;
	localparam logic [CfgIdxW-1:0] RegAlarmTime     = 3'd4;
	localparam logic [CfgIdxW-1:0] RegCountStep     = 3'd5;

	// Register reset values
	localparam logic signed [TempW-1:0] LowThresholdRst  = 11'sd0;
	localparam logic signed [TempW-1:0] HighThresholdRst = 11'sd100;
	localparam logic [TimeW-1:0]        AlarmTimeRst     = 16'd500;
	localparam logic [StepW-1:0]        CountStepRst     = 10'd100;

	// Configuration seen by every lane
	typedef struct packed {
		logic                    low_enable;
		logic signed [TempW-1:0] low_threshold;
		logic                    high_enable;
		logic signed [TempW-1:0] high_threshold;
		logic [TimeW-1:0]        trip_time;
		logic [StepW-1:0]        count_step;
	} dta_cfg_t;

endpackage

>>> rtl/dta_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dta_lane: one channel of the temperature alarm
// Holds the low and high time counters of one channel, advances them on
// each accepted beat and reports the alarm that the updated counters give.
// ---------------------------------------------------------------------------
module dta_lane
	import dta_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic signed [TempW-1:0] temp,
	input  dta_cfg_t                cfg,
	output logic                    alarm
);

	logic [CountW-1:0] low_cnt_q;
	logic [CountW-1:0] high_cnt_q;
	logic [CountW-1:0] low_nxt;
	logic [CountW-1:0] high_nxt;
	logic [CountW-1:0] time_ext;

	// Counter update: clear when in range, add while not past the alarm time.
	function automatic logic [CountW-1:0] advance(
		input logic [CountW-1:0] cnt,
		input logic              out_of_range,
		input logic [CountW-1:0] limit,
		input logic [StepW-1:0]  step
	);
		logic [CountW-1:0] res;
		if (!out_of_range) begin
			res = '0;
		end else if (cnt <= limit) begin
			res = cnt + {{(CountW-StepW){1'b0}}, step};
		end else begin
			res = cnt;
		end
		return res;
	endfunction

	assign time_ext = {1'b0, cfg.trip_time};

	// Next counter values; a disabled side is held at zero.
	always_comb begin
		low_nxt  = '0;
		high_nxt = '0;
		if (cfg.low_enable) begin
			low_nxt = advance(low_cnt_q, temp < cfg.low_threshold, time_ext,
				cfg.count_step);
		end
		if (cfg.high_enable) begin
			high_nxt = advance(high_cnt_q, temp > cfg.high_threshold, time_ext,
				cfg.count_step);
		end
	end

	// The alarm follows the counters as they stand after this beat.
	assign alarm = (low_nxt >= time_ext) || (high_nxt >= time_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_cnt_q  <= '0;
			high_cnt_q <= '0;
		end else if (accept) begin
			low_cnt_q  <= low_nxt;
			high_cnt_q <= high_nxt;
		end
	end

`ifndef SYNTH
	a_low_disabled_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.low_enable) |=> (low_cnt_q == '0))
		else $error("low counter not cleared while its side is disabled");

	a_high_disabled_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.high_enable) |=> (high_cnt_q == '0))
		else $error("high counter not cleared while its side is disabled");

	a_counts_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(low_cnt_q) && $stable(high_cnt_q)))
		else $error("counter moved without an accepted beat");
`endif

endmodule

>>> rtl/dta_merge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dta_merge: collects the lane alarms into one result beat
// Registers the alarm bits of all lanes and holds them until the
// downstream side takes the beat; it frees itself in the same cycle.
// ---------------------------------------------------------------------------
module dta_merge
	import dta_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [NumSlots-1:0] alarms,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OutDataW-1:0] out_data
);

	logic                valid_q;
	logic [NumSlots-1:0] alarms_q;

	// Room for a new beat when empty or when the held beat leaves now
	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			alarms_q <= alarms;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {{(OutDataW-NumSlots){1'b0}}, alarms_q};

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> free)
		else $error("result register overwritten while still held");

	a_accept_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_q)
		else $error("accepted beat did not produce a result");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_ready && !accept) |=> !valid_q)
		else $error("taken result still shown as valid");
`endif

endmodule

>>> rtl/debounced_temperature_alarm.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// debounced_temperature_alarm: debounced low/high alarm over three channels
//
// Channel  Direction  Beat content
// s_*      in         tdata: temp_ch0[10:0], temp_ch1[21:11], temp_ch2[32:22]
// m_*      out        tdata: alarm_ch0[0], alarm_ch1[1], alarm_ch2[2]
// cfg_*    in         write enable, register index, write data
//
// One sample beat is taken every cycle while s_tready is high; its alarm beat
// appears in the next cycle from the result register of the merge stage.
// The lanes compare and update their counters in the accepting cycle.
// Reset clears all counters and loads the register defaults.
// s_tready drops only while a result is held and m_tready is low.
// ---------------------------------------------------------------------------
module debounced_temperature_alarm
	import dta_pkg::*;
#(
	parameter int CHANNELS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // temp_ch0, temp_ch1, temp_ch2, zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // alarm_ch0, alarm_ch1, alarm_ch2, zero pad
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	dta_cfg_t            cfg_q;
	logic                s_fire;
	logic [NumSlots-1:0] lane_alarm;

	assign s_fire = s_tvalid && s_tready;

	// Register bank; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_enable     <= 1'b0;
			cfg_q.low_threshold  <= LowThresholdRst;
			cfg_q.high_enable    <= 1'b0;
			cfg_q.high_threshold <= HighThresholdRst;
			cfg_q.trip_time      <= AlarmTimeRst;
			cfg_q.count_step     <= CountStepRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegLowEnable:     cfg_q.low_enable     <= cfg_wdata[0];
				RegLowThreshold:  cfg_q.low_threshold  <= $signed(cfg_wdata[TempW-1:0]);
				RegHighEnable:    cfg_q.high_enable    <= cfg_wdata[0];
				RegHighThreshold: cfg_q.high_threshold <= $signed(cfg_wdata[TempW-1:0]);
				RegAlarmTime:     cfg_q.trip_time      <= cfg_wdata[TimeW-1:0];
				RegCountStep:     cfg_q.count_step     <= cfg_wdata[StepW-1:0];
				default: ;
			endcase
		end
	end

	// One lane per used channel; unused slots never alarm
	for (genvar i = 0; i < NumSlots; i++) begin : g_lane
		if (i < CHANNELS) begin : g_used
			dta_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.accept (s_fire),
				.temp   ($signed(s_tdata[i*TempW +: TempW])),
				.cfg    (cfg_q),
				.alarm  (lane_alarm[i])
			);
		end else begin : g_unused
			assign lane_alarm[i] = 1'b0;
		end
	end

	// Merge the lane alarms into the result beat
	dta_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_fire),
		.alarms    (lane_alarm),
		.free      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

`ifndef SYNTH
	a_unused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OutDataW-1:CHANNELS] == '0))
		else $error("alarm raised on an unused channel");

	a_zero_time_alarms: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && cfg_q.trip_time == '0) |=> m_tdata[0])
		else $error("zero alarm time did not raise the alarm");

	a_full_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |-> s_tready)
		else $error("input stalled while the result leaves");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && !cfg_q.low_enable && !cfg_q.high_enable
			&& cfg_q.trip_time != '0) |=> (m_tdata == '0))
		else $error("alarm raised with both sides disabled");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the debounced temperature alarm
// Sample beats carry three channel temperatures and are driven on the falling
// edge. An alarm tracker keeps its own copy of the registers and the per-channel
// low and high time counters and predicts the alarm beat for every sample that
// is accepted. Alarm beats are checked in order against those predictions.
// A short directed part covers the field extremes, zero alarm time, zero step,
// a lowered alarm time and unused register indexes. Runs of in-range and
// out-of-range samples under several register settings follow, with random gaps
// on both streams, a long output stall and a pause until the block drains.
// ---------------------------------------------------------------------------
module tb_top
	import dta_pkg::*;
();

	localparam int ChanCount = 3;

	// Indexes past the last register, which the block must ignore
	localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
	localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

	// Where a channel's temperature run sits relative to the thresholds
	typedef enum int {InRange, BelowLow, AboveHigh} region_t;

	// Predicts one alarm beat per accepted sample beat and checks the alarm stream.
	class alarm_tracker_t;
		logic                    low_en;
		logic                    high_en;
		logic signed [TempW-1:0] low_thr;
		logic signed [TempW-1:0] high_thr;
		logic [TimeW-1:0]        trip_time;
		logic [StepW-1:0]        step;
		logic [CountW-1:0]       low_cnt [NumSlots];
		logic [CountW-1:0]       high_cnt [NumSlots];
		logic [NumSlots-1:0]     expected_alarms [$];
		int                      mismatches;

		function new();
			low_en     = 1'b0;
			high_en    = 1'b0;
			low_thr    = LowThresholdRst;
			high_thr   = HighThresholdRst;
			trip_time  = AlarmTimeRst;
			step       = CountStepRst;
			foreach (low_cnt[ch]) begin
				low_cnt[ch]  = '0;
				high_cnt[ch] = '0;
			end
			mismatches = 0;
		endfunction

		function int pending();
			return expected_alarms.size();
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				RegLowEnable:     low_en     = val[0];
				RegLowThreshold:  low_thr    = val[TempW-1:0];
				RegHighEnable:    high_en    = val[0];
				RegHighThreshold: high_thr   = val[TempW-1:0];
				RegAlarmTime:     trip_time  = val[TimeW-1:0];
				RegCountStep:     step       = val[StepW-1:0];
				default: ;
			endcase
		endfunction

		// A counter clears in range and stops adding once it is past the alarm time.
		function logic [CountW-1:0] advance(logic [CountW-1:0] cnt, logic out_of_range);
			if (!out_of_range)
				return '0;
			if (cnt <= {1'b0, trip_time})
				return cnt + {{(CountW-StepW){1'b0}}, step};
			return cnt;
		endfunction

		function void take_sample(logic [InDataW-1:0] beat);
			logic signed [TempW-1:0] t;
			logic [NumSlots-1:0]     alarms;
			alarms = '0;
			for (int ch = 0; ch < NumSlots; ch++) begin
				t = beat[ch*TempW +: TempW];
				if (ch < ChanCount) begin
					low_cnt[ch]  = low_en ? advance(low_cnt[ch], t < low_thr) : '0;
					high_cnt[ch] = high_en ? advance(high_cnt[ch], t > high_thr) : '0;
					alarms[ch]   = (low_cnt[ch] >= {1'b0, trip_time}) ||
						(high_cnt[ch] >= {1'b0, trip_time});
				end else begin
					low_cnt[ch]  = '0;
					high_cnt[ch] = '0;
				end
			end
			expected_alarms.push_back(alarms);
		endfunction

		function void check_alarms(logic [OutDataW-1:0] beat);
			logic [NumSlots-1:0] want;
			if (expected_alarms.size() == 0) begin
				$error("alarm beat %0h arrived with no sample waiting", beat);
				mismatches++;
				return;
			end
			want = expected_alarms.pop_front();
			for (int ch = 0; ch < NumSlots; ch++) begin
				if (beat[ch] !== want[ch]) begin
					$error("alarm_ch%0d: expected %0b, got %0b", ch, want[ch], beat[ch]);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;   // temp_ch0, temp_ch1, temp_ch2, zero pad
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;   // alarm_ch0, alarm_ch1, alarm_ch2, zero pad
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	bit idle_on = 1'b1;
	int rx_hold = 0;

	alarm_tracker_t sb = new();

	debounced_temperature_alarm #(
		.CHANNELS(ChanCount)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both streams and the register port; alarms are checked before the
	// sample of the same edge is noted, as a result always belongs to an older beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_alarms(m_tdata);
			if (s_tvalid && s_tready)
				sb.take_sample(s_tdata);
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_wdata);
		end
	end

	// Receiver: random back-pressure, a long hold-off on request, none when idling is off.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (idle_on) begin
				m_tready <= ($urandom_range(99) >= 32);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog.
	initial begin
		#3_000_000;
		$display("tb_top failed");
		$finish;
	end

	// Offer one sample beat, with random gaps beforehand, and wait until it is taken.
	task automatic send_sample(input logic signed [TempW-1:0] t0, t1, t2);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(InDataW-3*TempW){1'b0}}, t2, t1, t0};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Stop offering and wait until every predicted alarm beat has been seen.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic le, input int lt, input logic he, input int ht,
		input int at, input int stp);
		write_reg(RegLowEnable, {{(CfgDataW-1){1'b0}}, le});
		write_reg(RegLowThreshold, CfgDataW'(lt));
		write_reg(RegHighEnable, {{(CfgDataW-1){1'b0}}, he});
		write_reg(RegHighThreshold, CfgDataW'(ht));
		write_reg(RegAlarmTime, CfgDataW'(at));
		write_reg(RegCountStep, CfgDataW'(stp));
		end_writes();
	endtask

	// A random temperature inside the wanted region, or anywhere if the region is empty.
	function automatic logic signed [TempW-1:0] pick_temp(region_t r, int lo_thr, int hi_thr);
		int lo;
		int hi;
		int v;
		lo = -1024;
		hi = 1023;
		case (r)
			BelowLow:  hi = lo_thr - 1;
			AboveHigh: lo = hi_thr + 1;
			default: begin
				lo = lo_thr;
				hi = hi_thr;
			end
		endcase
		if (lo > hi) begin
			lo = -1024;
			hi = 1023;
		end
		v = lo + int'($urandom_range(hi - lo));
		return v[TempW-1:0];
	endfunction

	// Main sequence.
	initial begin
		logic                    le;
		logic                    he;
		int                      lt;
		int                      ht;
		int                      at;
		int                      stp;
		int                      n_items;
		int                      max_run;
		region_t                 region [NumSlots];
		int                      run_left [NumSlots];
		logic signed [TempW-1:0] tv [NumSlots];

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Register defaults: both sides disabled, so extremes raise nothing.
		send_sample(-11'sd1024, 11'sd1023, 11'sd0);
		send_sample(11'sd1023, -11'sd1024, 11'sd100);
		send_sample(11'sd101, -11'sd1, -11'sd1024);
		settle();

		// Writes to indexes past the last register must change nothing.
		write_reg(RegSpare6, CfgDataW'($urandom));
		write_reg(RegSpare7, CfgDataW'($urandom));

		// Both sides on: counters ramp to the alarm and just past it, then clear.
		configure(1'b1, 0, 1'b1, 100, 300, 100);
		repeat (4)
			send_sample(-11'sd1024, 11'sd1023, 11'sd0);
		send_sample(11'sd0, 11'sd100, 11'sd1);
		settle();

		// Zero alarm time: every channel alarms with both sides disabled.
		configure(1'b0, 0, 1'b0, 100, 0, 100);
		send_sample(11'sd5, 11'sd50, -11'sd7);
		send_sample(-11'sd1024, 11'sd1023, 11'sd0);
		settle();

		// Zero step: counters never advance.
		configure(1'b1, 0, 1'b1, 100, 10, 0);
		send_sample(-11'sd50, 11'sd500, -11'sd1);
		send_sample(-11'sd50, 11'sd500, -11'sd1);
		settle();

		// Lowered alarm time: counters past the new value hold, then the high ones clear on disable.
		configure(1'b1, 0, 1'b1, 100, 1000, 400);
		repeat (4)
			send_sample(-11'sd5, 11'sd200, 11'sd50);
		settle();
		write_reg(RegAlarmTime, 16'd500);
		end_writes();
		repeat (2)
			send_sample(-11'sd5, 11'sd200, 11'sd50);
		settle();
		write_reg(RegHighEnable, '0);
		end_writes();
		send_sample(-11'sd5, 11'sd200, 11'sd50);
		send_sample(11'sd0, 11'sd0, 11'sd0);

		// Random phases: runs of in-range and out-of-range samples per channel.
		for (int p = 0; p < 8; p++) begin
			settle();
			idle_on = (p != 6);
			case (p)
				0: begin
					le = 1'b1; he = 1'b1; lt = 1023; ht = -1024; stp = 1023; at = 65535;
				end
				1: begin
					le = 1'b1; he = 1'b1; lt = -1024; ht = 1023; stp = 1; at = 0;
				end
				2: begin
					le = 1'b1; he = 1'b1;
					lt = int'($urandom_range(200)) - 100;
					ht = lt + int'($urandom_range(200));
					stp = 1;
					at = $urandom_range(8);
				end
				default: begin
					le = ($urandom_range(99) < 80);
					he = ($urandom_range(99) < 80);
					lt = int'($urandom_range(600)) - 300;
					ht = lt + int'($urandom_range(600));
					if (ht > 1023)
						ht = 1023;
					stp = $urandom_range(1, 1023);
					at = (p == 7) ? int'($urandom_range(65535)) : stp * int'($urandom_range(7));
					if (at > 65535)
						at = 65535;
				end
			endcase
			configure(le, lt, he, ht, at, stp);
			n_items = (p == 0) ? 90 : 60;
			max_run = (p == 0) ? 80 : 12;
			foreach (run_left[ch])
				run_left[ch] = 0;
			for (int i = 0; i < n_items; i++) begin
				// Long output stall while samples keep coming, and one full drain.
				if (p == 3 && i == 0)
					rx_hold = 60;
				if (p == 5 && i == 30)
					settle();
				for (int ch = 0; ch < NumSlots; ch++) begin
					if (run_left[ch] == 0) begin
						region[ch]   = region_t'($urandom_range(2));
						run_left[ch] = $urandom_range(1, max_run);
					end
					run_left[ch]--;
					if ($urandom_range(99) < 12)
						tv[ch] = TempW'($urandom);
					else
						tv[ch] = pick_temp(region[ch], lt, ht);
				end
				send_sample(tv[0], tv[1], tv[2]);
			end
		end

		settle();
		repeat (5) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/dta_pkg.sv
rtl/dta_lane.sv
rtl/dta_merge.sv
rtl/debounced_temperature_alarm.sv
bench/tb_top.sv
